/* hdl/cnm_pkg.sv */
// shared widths, register indexes and the carrier cosine table
package cnm_pkg;

   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_BITS = 8;
   localparam int LUT_BITS    = 5;
   localparam int COEF_BITS   = 7;
   localparam int MIX_BITS    = 15;
   localparam int CSR_BITS    = 2;

   // sine is the cosine table read a quarter cycle back
   localparam logic [LUT_BITS-1:0] QUARTER = LUT_BITS'(8);

   typedef enum logic [CSR_BITS-1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_PHASE_START  = 2'd1,
      CSR_COMPLEX_MODE = 2'd2
   } csr_index_type;

   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [MIX_BITS-1:0]    mix_type;

   // cosine over one cycle, scaled to 32
   function automatic coef_type cos_lut(input logic [LUT_BITS-1:0] k);
      coef_type v;
      case (k)
         5'd0:  v = 7'sd32;
         5'd1:  v = 7'sd31;
         5'd2:  v = 7'sd30;
         5'd3:  v = 7'sd27;
         5'd4:  v = 7'sd23;
         5'd5:  v = 7'sd18;
         5'd6:  v = 7'sd12;
         5'd7:  v = 7'sd6;
         5'd8:  v = 7'sd0;
         5'd9:  v = -7'sd6;
         5'd10: v = -7'sd12;
         5'd11: v = -7'sd18;
         5'd12: v = -7'sd23;
         5'd13: v = -7'sd27;
         5'd14: v = -7'sd30;
         5'd15: v = -7'sd31;
         5'd16: v = -7'sd32;
         5'd17: v = -7'sd31;
         5'd18: v = -7'sd30;
         5'd19: v = -7'sd27;
         5'd20: v = -7'sd23;
         5'd21: v = -7'sd18;
         5'd22: v = -7'sd12;
         5'd23: v = -7'sd6;
         5'd24: v = 7'sd0;
         5'd25: v = 7'sd6;
         5'd26: v = 7'sd12;
         5'd27: v = 7'sd18;
         5'd28: v = 7'sd23;
         5'd29: v = 7'sd27;
         5'd30: v = 7'sd30;
         5'd31: v = 7'sd31;
         default: v = 7'sd0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/cnm_mixer.sv */
// table lookup and complex rotation of one sample
module cnm_mixer
   import cnm_pkg::*;
(
   input  logic [LUT_BITS-1:0] lut_index,
   input  sample_type          sample_i,
   input  sample_type          sample_q,
   input  logic                complex_mode,
   output mix_type             mixed_i,
   output mix_type             mixed_q
);

   coef_type   c;
   coef_type   s;
   sample_type q_eff;
   mix_type    c_ext;
   mix_type    s_ext;
   mix_type    i_ext;
   mix_type    q_ext;

   always_comb begin
      c     = cos_lut(lut_index);
      s     = cos_lut(lut_index - QUARTER);
      // real mode drops the quadrature term
      q_eff = complex_mode ? sample_q : '0;
      c_ext = {{(MIX_BITS-COEF_BITS){c[COEF_BITS-1]}}, c};
      s_ext = {{(MIX_BITS-COEF_BITS){s[COEF_BITS-1]}}, s};
      i_ext = {{(MIX_BITS-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
      q_ext = {{(MIX_BITS-SAMPLE_BITS){q_eff[SAMPLE_BITS-1]}}, q_eff};
      mixed_i = MIX_BITS'(c_ext * i_ext - s_ext * q_ext);
      mixed_q = MIX_BITS'(s_ext * i_ext + c_ext * q_ext);
   end

endmodule

/* hdl/carrier_nco_mixer_top.sv */
// Carrier NCO and mixer: each request carries one signed I/Q sample that is
// rotated by a local carrier from a 32-bit phase accumulator and a 32-entry
// cosine table (values -32..32). The accumulator advances by phase_step after
// every sample, and a request with restart set first reloads it from
// phase_start. One request is taken per clock while req_stall is low; the
// phase add is captured in the input register, then the table lookup and
// multiplies in the result register, which holds while rsp_stall is high.
// The user writes registers only while no request is in flight; unenforced.
module carrier_nco_mixer_top
   import cnm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_BITS-1:0]    csr_index,
   input  logic [PHASE_BITS-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sample_type             req_sample_i,
   input  sample_type             req_sample_q,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mix_type                rsp_mixed_i,
   output mix_type                rsp_mixed_q,
   output logic [PHASE_BITS-1:0]  rsp_phase_after
);

   logic [PHASE_BITS-1:0] step_ff;
   logic [PHASE_BITS-1:0] start_ff;
   logic                  mode_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_use;

   logic                  s1_valid_ff;
   logic [LUT_BITS-1:0]   s1_index_ff;
   sample_type            s1_i_ff;
   sample_type            s1_q_ff;
   logic [PHASE_BITS-1:0] s1_phase_ff;

   logic                  s2_valid_ff;
   mix_type               s2_mi_ff;
   mix_type               s2_mq_ff;
   logic [PHASE_BITS-1:0] s2_phase_ff;

   mix_type               mix_i;
   mix_type               mix_q;
   logic                  s2_move;
   logic                  s1_move;
   logic                  req_take;

   assign s2_move   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;
   assign req_take  = req_valid && s1_move;

   always_comb begin
      phase_use = req_restart ? start_ff : phase_ff;
      phase_in  = phase_use + step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         start_ff <= '0;
         mode_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP:   step_ff  <= csr_wdata;
            CSR_PHASE_START:  start_ff <= csr_wdata;
            CSR_COMPLEX_MODE: mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff <= phase_in;
         end
         if (s1_move) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         // table index is the top phase bits before the step
         s1_index_ff <= phase_use[PHASE_BITS-1 -: LUT_BITS];
         s1_i_ff     <= req_sample_i;
         s1_q_ff     <= req_sample_q;
         s1_phase_ff <= phase_in;
      end
      if (s2_move && s1_valid_ff) begin
         s2_mi_ff    <= mix_i;
         s2_mq_ff    <= mix_q;
         s2_phase_ff <= s1_phase_ff;
      end
   end

   cnm_mixer u_mixer (
      .lut_index    (s1_index_ff),
      .sample_i     (s1_i_ff),
      .sample_q     (s1_q_ff),
      .complex_mode (mode_ff),
      .mixed_i      (mix_i),
      .mixed_q      (mix_q)
   );

   assign rsp_valid       = s2_valid_ff;
   assign rsp_mixed_i     = s2_mi_ff;
   assign rsp_mixed_q     = s2_mq_ff;
   assign rsp_phase_after = s2_phase_ff;

endmodule
